>>> hw/rtl/bmd_pkg.sv
// Package for the 2x2 AND bitmap decimator.
// Holds sizes, the row-length helper, the block reduction and the stage struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmd_pkg;

   localparam int MAX_ROW_BYTES = 512;
   localparam int COL_W         = $clog2(MAX_ROW_BYTES);
   localparam int WIDTH_W       = 13;
   localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd640;

   // Information carried from the memory access stage to the pack stage
   typedef struct packed {
      logic       odd_row;
      logic       col_odd;
      logic       row_done;
      logic [7:0] lower;
   } stage_info_type;

   // Last byte column of a row: ceil(width / 8) - 1, clamped to 0 .. MAX_ROW_BYTES-1
   function automatic logic [COL_W-1:0] calc_last(input logic [WIDTH_W-1:0] width);
      logic [WIDTH_W:0] bytes;
      bytes = ({1'b0, width} + (WIDTH_W+1)'(7)) >> 3;
      if (bytes == '0) begin
         bytes = (WIDTH_W+1)'(1);
      end
      if (bytes > (WIDTH_W+1)'(MAX_ROW_BYTES)) begin
         bytes = (WIDTH_W+1)'(MAX_ROW_BYTES);
      end
      return COL_W'(bytes - (WIDTH_W+1)'(1));
   endfunction

   // Pair k of both rows black gives nibble bit 3-k
   function automatic logic [3:0] block_nibble(input logic [7:0] upper,
                                               input logic [7:0] lower);
      logic [3:0] nib;
      nib = '0;
      for (int k = 0; k < 4; k++) begin
         nib[3-k] = (&upper[7-2*k -: 2]) & (&lower[7-2*k -: 2]);
      end
      return nib;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bmd_line_ram.sv
// Generic single-write, single-read synchronous RAM used as the line buffer.
// Read data is registered and holds while no read is issued. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmd_line_ram #(
   parameter int DEPTH  = 512,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, hold when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bmd_pack.sv
// Pack stage: combines the stored even-row byte with the odd-row byte,
// assembles output bytes and holds them in the result register. Uses bmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmd_pack
   import bmd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire stage_info_type in_info,
   input  wire logic [7:0]     upper,
   output logic                out_valid,
   input  wire logic           out_ready,
   output logic [7:0]          out_byte,
   output logic                out_row_end
);

   logic           s1_valid_ff, s1_valid_in;
   stage_info_type s1_info_ff;
   logic [7:0]     packed_ff, packed_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff;
   logic           out_row_end_ff;
   logic [3:0]     nib;
   logic           emit;
   logic           s1_go;

   // Reduce the 2x2 blocks and decide whether a request leaves here
   assign nib   = block_nibble(upper, s1_info_ff.lower);
   assign emit  = s1_info_ff.odd_row & (s1_info_ff.col_odd | s1_info_ff.row_done);
   assign s1_go = s1_valid_ff & (~emit | ~out_valid_ff | out_ready);

   assign in_ready = ~s1_valid_ff | s1_go;

   // Even column sets the high nibble, odd column fills the low one
   always_comb begin
      packed_in = packed_ff;
      if (s1_go && s1_info_ff.odd_row) begin
         if (!s1_info_ff.col_odd) begin
            packed_in = {nib, 4'b0000};
         end else begin
            packed_in = {packed_ff[7:4], nib};
         end
      end
   end

   // Stage and result valid flags
   always_comb begin
      s1_valid_in = in_ready ? in_valid : s1_valid_ff;
      if (s1_go && emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         packed_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         packed_ff    <= packed_in;
      end
   end

   // Payload: advance stage info, load result register
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_info_ff <= in_info;
      end
      if (s1_go && emit) begin
         out_byte_ff    <= packed_in;
         out_row_end_ff <= s1_info_ff.row_done;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_byte    = out_byte_ff;
   assign out_row_end = out_row_end_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_2x2_and_decimator.sv
// 2x2 AND decimator for a packed 1-bit bitmap, byte stream in and out.
// Read byte and stage info are registered, then the result register drives rsp.
// One request per cycle unless rsp stalls; each makes one line-buffer access.
// Reset: synchronous; clears column, row parity, packed byte and valid flags,
// and sets row_width to 640. Line buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_2x2_and_decimator
   import bmd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,   // [7:0] in_byte
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,   // [7:0] out_byte
   output logic                    rsp_tlast,   // row_end
   input  wire logic               csr_wr_en,
   input  wire logic [WIDTH_W-1:0] csr_wr_data  // row_width
);

   logic [COL_W-1:0] last_ff, last_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             odd_ff, odd_in;
   logic             accept;
   logic             row_done;
   logic             pack_ready;
   logic [7:0]       upper;
   stage_info_type   info;

   assign req_tready = pack_ready;
   assign accept     = req_tvalid & pack_ready;
   assign row_done   = (col_ff >= last_ff);

   // Row length follows the width register
   assign last_in = csr_wr_en ? calc_last(csr_wr_data) : last_ff;

   // Advance column, toggle row parity at end of row
   always_comb begin
      col_in = col_ff;
      odd_in = odd_ff;
      if (accept) begin
         if (row_done) begin
            col_in = '0;
            odd_in = ~odd_ff;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= calc_last(ROW_WIDTH_RESET);
         col_ff  <= '0;
         odd_ff  <= 1'b0;
      end else begin
         last_ff <= last_in;
         col_ff  <= col_in;
         odd_ff  <= odd_in;
      end
   end

   // Even rows write the line buffer, odd rows read it
   bmd_line_ram #(
      .DEPTH (MAX_ROW_BYTES),
      .WIDTH (8),
      .ADDR_W(COL_W)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (accept & ~odd_ff),
      .wr_addr(col_ff),
      .wr_data(req_tdata),
      .rd_en  (accept & odd_ff),
      .rd_addr(col_ff),
      .rd_data(upper)
   );

   assign info.odd_row  = odd_ff;
   assign info.col_odd  = col_ff[0];
   assign info.row_done = row_done;
   assign info.lower    = req_tdata;

   bmd_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (pack_ready),
      .in_info    (info),
      .upper      (upper),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_row_end(rsp_tlast)
   );

endmodule

`default_nettype wire

>>> dv/bitmap_2x2_and_decimator_test.sv
// Self-checking testbench for the 2x2 AND bitmap decimator.
// Streams bitmap rows through the block, predicts each decimated byte and checks it.
// Depends on bmd_pkg and bitmap_2x2_and_decimator.
`timescale 1ns / 1ps

module bitmap_2x2_and_decimator_test;
   import bmd_pkg::*;

   localparam int RUN_LIMIT_NS  = 1_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_BYTES  = 450;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       row_end;
   } decimated_type;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata   = '0;
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [7:0]         rsp_tdata;
   logic               rsp_tlast;
   logic               csr_wr_en   = 1'b0;
   logic [WIDTH_W-1:0] csr_wr_data = '0;

   // Stimulus and expectation stores
   logic [7:0]    bitmap_queue[$];
   decimated_type decimated_queue[$];

   // Predicted block state
   logic [7:0]         line_mem[MAX_ROW_BYTES];
   logic [8:0]         byte_col;
   logic               odd_row;
   logic [7:0]         packed_byte;
   logic [WIDTH_W-1:0] row_width_q;

   // Generator's view of the row position, used to keep odd-row reads on written entries
   bit                 written[MAX_ROW_BYTES];
   int                 gen_col;
   bit                 gen_odd;
   logic [WIDTH_W-1:0] gen_width;

   // Handshake and idling control
   bit req_taken;
   bit hold_rsp;
   int req_gap;
   int rsp_gap;
   int idle_pct;
   int bytes_taken;
   int bytes_queued;
   int error_count;

   bitmap_2x2_and_decimator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [7:0] in_byte
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [7:0] out_byte
      .rsp_tlast   (rsp_tlast),    // row_end
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)   // row_width
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Last byte column of a row for a given pixel width, clamped to the line buffer
   function automatic int last_byte_col(input logic [WIDTH_W-1:0] width);
      int n;
      n = (int'(width) + 7) / 8;
      if (n < 1) n = 1;
      if (n > MAX_ROW_BYTES) n = MAX_ROW_BYTES;
      return n - 1;
   endfunction

   // Store an even-row byte, or fold an odd-row byte with the stored one
   task automatic decimate_byte(input logic [7:0] lower);
      logic [3:0]    nib;
      logic [7:0]    upper;
      bit            row_done;
      decimated_type res;
      row_done = int'(byte_col) >= last_byte_col(row_width_q);
      if (!odd_row) begin
         line_mem[byte_col] = lower;
      end else begin
         upper = line_mem[byte_col];
         for (int k = 0; k < 4; k++) begin
            nib[3-k] = (upper[7-2*k -: 2] == 2'b11) && (lower[7-2*k -: 2] == 2'b11);
         end
         if (!byte_col[0]) begin
            packed_byte = {nib, 4'h0};
         end else begin
            packed_byte[3:0] = nib;
         end
         if (byte_col[0] || row_done) begin
            res.out_byte = packed_byte;
            res.row_end  = row_done;
            decimated_queue.push_back(res);
         end
      end
      if (row_done) begin
         byte_col = '0;
         odd_row  = ~odd_row;
      end else begin
         byte_col = byte_col + 9'd1;
      end
   endtask

   task automatic report_mismatch(input string what, input decimated_type exp);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR: %s: expected data %02h last %0b, got data %02h last %0b",
                  what, exp.out_byte, exp.row_end, rsp_tdata, rsp_tlast);
      end
   endtask

   // Sample handshakes, update the prediction and check results
   always @(posedge clock) begin
      decimated_type exp;
      req_taken = !reset && req_tvalid && req_tready;
      if (reset) begin
         byte_col    = '0;
         odd_row     = 1'b0;
         packed_byte = '0;
         row_width_q = ROW_WIDTH_RESET;
         decimated_queue.delete();
      end else begin
         if (csr_wr_en) begin
            row_width_q = csr_wr_data;
         end
         if (req_taken) begin
            decimate_byte(req_tdata);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (decimated_queue.size() == 0) begin
               exp = '0;
               report_mismatch("decimated byte with none expected", exp);
            end else begin
               exp = decimated_queue.pop_front();
               if (rsp_tdata !== exp.out_byte || rsp_tlast !== exp.row_end) begin
                  report_mismatch("decimated byte mismatch", exp);
               end
            end
         end
      end
   end

   // Request driver: hold an offered byte until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (bitmap_queue.size() != 0) begin
            req_tdata  <= bitmap_queue.pop_front();
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 99) < idle_pct) req_gap = $urandom_range(1, 8);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: stall in bursts, or for a long stretch on request
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < idle_pct) rsp_gap = $urandom_range(1, 8);
      end
   end

   // Long receiver hold-off in the middle of an odd row, so the block backs up
   initial begin
      hold_rsp = 1'b0;
      wait (bytes_taken >= 700);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [7:0] random_pixels();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom);
         1:       return 8'hFF;
         2:       return 8'($urandom | $urandom);
         default: return ~8'($urandom & $urandom & $urandom);
      endcase
   endfunction

   // Queue one request and advance the generator's row position
   task automatic push_pixels(input logic [7:0] pixels);
      bitmap_queue.push_back(pixels);
      bytes_queued++;
      if (!gen_odd) written[gen_col] = 1'b1;
      if (gen_col >= last_byte_col(gen_width)) begin
         gen_col = 0;
         gen_odd = ~gen_odd;
      end else begin
         gen_col++;
      end
   endtask

   // Queue random bytes until the given number of odd rows has closed
   task automatic push_row_pairs(input int pairs);
      int done;
      done = 0;
      while (done < pairs) begin
         if (gen_odd && gen_col >= last_byte_col(gen_width)) done++;
         push_pixels(random_pixels());
      end
   endtask

   // Wait until every request is taken and every result is checked, then settle
   task automatic wait_quiet();
      do @(posedge clock);
      while (bitmap_queue.size() != 0 || req_tvalid || decimated_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A new width must not make the rest of an odd row read unwritten entries
   function automatic bit width_is_safe(input logic [WIDTH_W-1:0] width);
      if (!gen_odd) return 1'b1;
      for (int c = gen_col; c <= last_byte_col(width); c++) begin
         if (!written[c]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic set_width(input logic [WIDTH_W-1:0] width);
      wait_quiet();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= width;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      gen_width = width;
   endtask

   initial begin : stimulus
      int                 random_start;
      int                 extra;
      logic [WIDTH_W-1:0] width;
      gen_col      = 0;
      gen_odd      = 1'b0;
      gen_width    = ROW_WIDTH_RESET;
      idle_pct     = 0;
      bytes_taken  = 0;
      bytes_queued = 0;
      error_count  = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // One row pair at the width left by reset
      idle_pct = 20;
      push_row_pairs(1);

      // Zero width: one byte per row
      set_width(13'd0);
      push_pixels(8'hFF);
      push_pixels(8'hFF);

      // Odd width with an odd byte count: last byte of the row is an even column
      set_width(13'd17);
      push_pixels(8'hFF);
      push_pixels(8'h0F);
      push_pixels(8'hCC);
      push_pixels(8'hC3);
      push_pixels(8'hFF);
      push_pixels(8'h33);

      // Narrow the width in the middle of an odd row: the next byte ends it
      set_width(13'd32);
      push_pixels(8'hAA);
      push_pixels(8'h55);
      push_pixels(8'hFF);
      push_pixels(8'h00);
      push_pixels(8'hFF);
      push_pixels(8'h30);
      push_pixels(8'hC0);
      set_width(13'd8);
      push_pixels(8'h0C);

      // Narrow the width in the middle of an even row, then finish the pair
      set_width(13'd24);
      push_pixels(8'h03);
      push_pixels(8'hFF);
      set_width(13'd16);
      push_pixels(8'h00);
      push_pixels(8'hFF);
      push_pixels(8'h03);

      // Widest row, then a width beyond the buffer while the odd row is open
      idle_pct = 10;
      set_width(13'd4096);
      repeat (MAX_ROW_BYTES + 20) push_pixels(random_pixels());
      set_width(13'd8191);
      repeat (12) push_pixels(random_pixels());

      // Random widths and row pairs, sometimes stopping mid-row
      random_start = bytes_queued;
      while (bytes_queued < random_start + RANDOM_BYTES) begin
         case ($urandom_range(0, 9))
            0:       width = WIDTH_W'($urandom_range(0, 1));
            1, 2:    width = WIDTH_W'(2 * $urandom_range(33, 200));
            3:       width = WIDTH_W'($urandom_range(1, 63) | 1);
            default: width = WIDTH_W'(2 * $urandom_range(1, 32));
         endcase
         if (!width_is_safe(width)) width = gen_width;
         wait_quiet();
         if (bytes_queued - random_start > RANDOM_BYTES - 200) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               2:       idle_pct = 25;
               default: idle_pct = 50;
            endcase
         end
         set_width(width);
         push_row_pairs($urandom_range(1, 3));
         if ($urandom_range(0, 3) == 0) begin
            extra = $urandom_range(1, last_byte_col(gen_width) + 1);
            repeat (extra) push_pixels(random_pixels());
         end
      end

      wait_quiet();
      if (error_count == 0 && decimated_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/bmd_pkg.sv
hw/rtl/bmd_line_ram.sv
hw/rtl/bmd_pack.sv
hw/rtl/bitmap_2x2_and_decimator.sv
dv/bitmap_2x2_and_decimator_test.sv
